### design/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Types, fixed constants and the CORDIC angle table for the linear chirp
// sample core.
// ----------------------------------------------------------------------------
package lcs_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_START_FREQ = 2'd0,
        CFG_STOP_FREQ  = 2'd1,
        CFG_SWEEP_DUR  = 2'd2,
        CFG_AMPLITUDE  = 2'd3
    } t_cfg_idx;

    // Rate divider sequencer states.
    typedef enum logic [1:0] {
        DIV_IDLE = 2'b01,
        DIV_RUN  = 2'b10
    } t_div_state;

    // CORDIC start value 0.60725 in Q2.30.
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    // Two pi in Q3.29.
    localparam logic [31:0] TWO_PI_Q29      = 32'd3373259426;
    // Saturation point of the frequency offset magnitude.
    localparam logic [63:0] FREQ_SAT        = 64'h4000_0000_0000_0000;

    // Angle of atan(2^-i) in 2^-32 turns.
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] val;
        case (idx)
            0:  val = 32'h20000000;
            1:  val = 32'h12E4051E;
            2:  val = 32'h09FB385B;
            3:  val = 32'h051111D4;
            4:  val = 32'h028B0D43;
            5:  val = 32'h0145D7E1;
            6:  val = 32'h00A2F61E;
            7:  val = 32'h00517C55;
            8:  val = 32'h0028BE53;
            9:  val = 32'h00145F2F;
            10: val = 32'h000A2F98;
            11: val = 32'h000517CC;
            12: val = 32'h00028BE6;
            13: val = 32'h000145F3;
            14: val = 32'h0000A2FA;
            15: val = 32'h0000517D;
            16: val = 32'h000028BE;
            17: val = 32'h0000145F;
            18: val = 32'h00000A30;
            19: val = 32'h00000518;
            20: val = 32'h0000028C;
            21: val = 32'h00000146;
            22: val = 32'h000000A3;
            23: val = 32'h00000051;
            24: val = 32'h00000029;
            25: val = 32'h00000014;
            26: val = 32'h0000000A;
            27: val = 32'h00000005;
            28: val = 32'h00000003;
            29: val = 32'h00000001;
            30: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

### design/linear_chirp_sample_core.sv
// ----------------------------------------------------------------------------
// linear_chirp_sample_core
// One sample of a linear frequency sweep per time value: A*sin(phase) and
// its time derivative, through a pipelined quadrant-split CORDIC.
// ----------------------------------------------------------------------------
// A start transfer reaches o_valid through stages 1 to 5, the CORDIC stages,
// the quarter-turn rotation, P1 to P4 and the output register.
// Throughput: one time value per clock while busy is low; the pipeline never
// stalls and the receiver takes every result in its strobe cycle.
// After reset and after every register write, busy stays high while the
// serial divider recomputes the sweep rate.
// Reset is synchronous and active low; it loads the default registers.
module linear_chirp_sample_core #(
    parameter int CORDIC_STAGES = 24,
    parameter int FRAC_BITS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata,
    input  logic [31:0]        i_time_point,
    output logic               o_valid,
    output logic signed [31:0] o_displacement,
    output logic signed [47:0] o_velocity
);
    import lcs_pkg::*;

    localparam int DIV_W  = 32 + FRAC_BITS;          // dividend and rate width
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int KHI_W  = DIV_W - 32;               // upper rate bits
    localparam int KT_W   = DIV_W + 32;               // rate times time
    localparam int SUM_W  = KT_W + 32;
    localparam int NB     = 3 * FRAC_BITS + 1;        // bits kept of k*t*t
    localparam int X_W    = 34;
    localparam int Z_W    = 34;
    localparam int VSH    = 30 + FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [31:0] r_start_freq, r_stop_freq, r_sweep_dur, r_amplitude;
    logic        r_div_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_freq <= 32'(1) << FRAC_BITS;
            r_stop_freq  <= 32'(10) << FRAC_BITS;
            r_sweep_dur  <= 32'(5) << FRAC_BITS;
            r_amplitude  <= 32'(1) << FRAC_BITS;
            r_div_req    <= 1'b1;
        end else begin
            r_div_req <= i_cfg_we;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_START_FREQ: r_start_freq <= i_cfg_wdata;
                    CFG_STOP_FREQ:  r_stop_freq  <= i_cfg_wdata;
                    CFG_SWEEP_DUR:  r_sweep_dur  <= i_cfg_wdata;
                    CFG_AMPLITUDE:  r_amplitude  <= i_cfg_wdata;
                    default:        r_start_freq <= r_start_freq;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Serial restoring divider for the sweep rate, one quotient bit a cycle.
    // ------------------------------------------------------------------
    t_div_state         r_state;
    logic [DIV_W-1:0]   r_div_dq;
    logic [31:0]        r_div_rem;
    logic [CNT_W-1:0]   r_div_cnt;
    logic               r_div_neg, r_div_zero;
    logic [DIV_W-1:0]   r_kmag;
    logic               r_k_neg;
    logic [32:0]        n_trial;
    logic               n_ge;
    logic [31:0]        n_diff;

    always_comb begin
        n_trial = {r_div_rem, r_div_dq[DIV_W-1]};
        n_ge    = n_trial >= {1'b0, r_sweep_dur};
        n_diff  = (r_stop_freq < r_start_freq) ? (r_start_freq - r_stop_freq)
                                                : (r_stop_freq - r_start_freq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_kmag  <= '0;
            r_k_neg <= 1'b0;
        end else if (r_div_req) begin
            r_state    <= DIV_RUN;
            r_div_dq   <= {n_diff, {FRAC_BITS{1'b0}}};
            r_div_rem  <= '0;
            r_div_cnt  <= CNT_W'(DIV_W);
            r_div_neg  <= r_stop_freq < r_start_freq;
            r_div_zero <= r_sweep_dur == 32'd0;
        end else begin
            case (r_state)
                DIV_RUN: begin
                    if (r_div_cnt != '0) begin
                        r_div_rem <= n_ge ? 32'(n_trial - {1'b0, r_sweep_dur})
                                          : n_trial[31:0];
                        r_div_dq  <= {r_div_dq[DIV_W-2:0], n_ge};
                        r_div_cnt <= r_div_cnt - 1'b1;
                    end else begin
                        r_kmag  <= r_div_zero ? '0 : r_div_dq;
                        r_k_neg <= r_div_neg & ~r_div_zero & (r_div_dq != '0);
                        r_state <= DIV_IDLE;
                    end
                end
                default: r_state <= DIV_IDLE;
            endcase
        end
    end

    assign busy = r_div_req | (r_state != DIV_IDLE);

    logic w_accept;
    assign w_accept = start & ~busy;

    // ------------------------------------------------------------------
    // Stage 1: products f0*t and rate*t in two halves.
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    logic [31:0]       r_s1_t;
    logic [63:0]       r_s1_f0t, r_s1_klo;
    logic [KHI_W+31:0] r_s1_khi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_valid <= 1'b0;
        else          r_s1_valid <= w_accept;
        r_s1_t   <= i_time_point;
        r_s1_f0t <= r_start_freq * i_time_point;
        r_s1_klo <= r_kmag[31:0] * i_time_point;
        r_s1_khi <= r_kmag[DIV_W-1:32] * i_time_point;
    end

    // ------------------------------------------------------------------
    // Stage 2: assemble k*t and take the f0*t phase term.
    // ------------------------------------------------------------------
    logic            r_s2_valid;
    logic [31:0]     r_s2_t, r_s2_term1;
    logic [KT_W-1:0] r_s2_kt;
    logic [95:0]     n_f0t_sh;

    assign n_f0t_sh = {r_s1_f0t, 32'b0} >> (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_valid <= 1'b0;
        else          r_s2_valid <= r_s1_valid;
        r_s2_t     <= r_s1_t;
        r_s2_term1 <= n_f0t_sh[31:0];
        r_s2_kt    <= KT_W'(r_s1_klo) + {r_s1_khi, 32'b0};
    end

    // ------------------------------------------------------------------
    // Stage 3: partial products of k*t*t; saturated frequency offset.
    // ------------------------------------------------------------------
    logic              r_s3_valid;
    logic [31:0]       r_s3_term1;
    logic [63:0]       r_s3_c0, r_s3_c1;
    logic [KT_W-33:0]  r_s3_c2;
    logic [62:0]       r_s3_ktsat;
    logic [63:0]       n_kts;

    assign n_kts = r_s2_kt[KT_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_valid <= 1'b0;
        else          r_s3_valid <= r_s2_valid;
        r_s3_term1 <= r_s2_term1;
        r_s3_c0    <= r_s2_kt[31:0] * r_s2_t;
        r_s3_c1    <= r_s2_kt[63:32] * r_s2_t;
        r_s3_c2    <= r_s2_kt[KT_W-1:64] * r_s2_t;
        r_s3_ktsat <= (n_kts > FREQ_SAT) ? FREQ_SAT[62:0] : n_kts[62:0];
    end

    // ------------------------------------------------------------------
    // Stage 4: sum k*t*t modulo its kept width; instantaneous frequency.
    // ------------------------------------------------------------------
    logic               r_s4_valid;
    logic [31:0]        r_s4_term1;
    logic [NB-1:0]      r_s4_ktt;
    logic signed [63:0] r_s4_f;
    logic [SUM_W-1:0]   n_ktt_sum;
    logic signed [63:0] n_f0_s, n_kt_s;

    always_comb begin
        n_ktt_sum = SUM_W'(r_s3_c0) + (SUM_W'(r_s3_c1) << 32)
                  + (SUM_W'(r_s3_c2) << 64);
        n_f0_s    = $signed({32'b0, r_start_freq});
        n_kt_s    = $signed({1'b0, r_s3_ktsat});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4_valid <= 1'b0;
        else          r_s4_valid <= r_s3_valid;
        r_s4_term1 <= r_s3_term1;
        r_s4_ktt   <= n_ktt_sum[NB-1:0];
        r_s4_f     <= r_k_neg ? (n_f0_s - n_kt_s) : (n_f0_s + n_kt_s);
    end

    // ------------------------------------------------------------------
    // Stage 5: signed chirp term and total phase in turns.
    // ------------------------------------------------------------------
    logic               r_s5_valid;
    logic [31:0]        r_s5_phase;
    logic signed [63:0] r_s5_f;
    logic [NB-1:0]      n_kttn;
    logic [NB+31:0]     n_ktt_sh;

    always_comb begin
        n_kttn   = r_k_neg ? (~r_s4_ktt + 1'b1) : r_s4_ktt;
        n_ktt_sh = {n_kttn, 32'b0} >> NB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s5_valid <= 1'b0;
        else          r_s5_valid <= r_s4_valid;
        r_s5_phase <= r_s4_term1 + n_ktt_sh[31:0];
        r_s5_f     <= r_s4_f;
    end

    // ------------------------------------------------------------------
    // CORDIC: quadrant split, then one rotation per register stage.
    // ------------------------------------------------------------------
    logic [31:0]           n_qsum, n_resid;
    logic [1:0]            n_q;

    always_comb begin
        n_qsum  = r_s5_phase + 32'h2000_0000;
        n_q     = n_qsum[31:30];
        n_resid = r_s5_phase - {n_q, 30'b0};
    end

    logic signed [X_W-1:0] w_cx [CORDIC_STAGES];
    logic signed [X_W-1:0] w_cy [CORDIC_STAGES];
    logic signed [Z_W-1:0] w_cz [CORDIC_STAGES];
    logic                  w_cv [CORDIC_STAGES];
    logic [1:0]            w_cq [CORDIC_STAGES];
    logic signed [63:0]    w_cf [CORDIC_STAGES];
    logic signed [X_W-1:0] r_cx [CORDIC_STAGES];
    logic signed [X_W-1:0] r_cy [CORDIC_STAGES];
    logic signed [Z_W-1:0] r_cz [CORDIC_STAGES];
    logic                  r_cv [CORDIC_STAGES];
    logic [1:0]            r_cq [CORDIC_STAGES];
    logic signed [63:0]    r_cf [CORDIC_STAGES];

    assign w_cx[0] = $signed({2'b00, CORDIC_GAIN_Q30});
    assign w_cy[0] = '0;
    assign w_cz[0] = $signed({{(Z_W-32){n_resid[31]}}, n_resid});
    assign w_cv[0] = r_s5_valid;
    assign w_cq[0] = n_q;
    assign w_cf[0] = r_s5_f;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        if (g > 0) begin : g_link
            assign w_cx[g] = r_cx[g-1];
            assign w_cy[g] = r_cy[g-1];
            assign w_cz[g] = r_cz[g-1];
            assign w_cv[g] = r_cv[g-1];
            assign w_cq[g] = r_cq[g-1];
            assign w_cf[g] = r_cf[g-1];
        end
        localparam logic [Z_W-1:0] ANG = {{(Z_W-32){1'b0}}, atan_turn(g)};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_cv[g] <= 1'b0;
            else          r_cv[g] <= w_cv[g];
            r_cq[g] <= w_cq[g];
            r_cf[g] <= w_cf[g];
            if (!w_cz[g][Z_W-1]) begin
                r_cx[g] <= w_cx[g] - (w_cy[g] >>> g);
                r_cy[g] <= w_cy[g] + (w_cx[g] >>> g);
                r_cz[g] <= w_cz[g] - $signed(ANG);
            end else begin
                r_cx[g] <= w_cx[g] + (w_cy[g] >>> g);
                r_cy[g] <= w_cy[g] - (w_cx[g] >>> g);
                r_cz[g] <= w_cz[g] + $signed(ANG);
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotate by the quarter turns to get cos and sin.
    // ------------------------------------------------------------------
    logic                  r_rt_valid;
    logic signed [X_W-1:0] r_rt_c, r_rt_s;
    logic signed [63:0]    r_rt_f;
    logic signed [X_W-1:0] n_c, n_s, w_lx, w_ly;

    assign w_lx = r_cx[CORDIC_STAGES-1];
    assign w_ly = r_cy[CORDIC_STAGES-1];

    always_comb begin
        case (r_cq[CORDIC_STAGES-1])
            2'd0: begin n_c = w_lx;  n_s = w_ly;  end
            2'd1: begin n_c = -w_ly; n_s = w_lx;  end
            2'd2: begin n_c = -w_lx; n_s = -w_ly; end
            default: begin n_c = w_ly; n_s = -w_lx; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rt_valid <= 1'b0;
        else          r_rt_valid <= r_cv[CORDIC_STAGES-1];
        r_rt_c <= n_c;
        r_rt_s <= n_s;
        r_rt_f <= r_cf[CORDIC_STAGES-1];
    end

    // ------------------------------------------------------------------
    // P1: A*sin product, |cos|*2pi product, result sign.
    // ------------------------------------------------------------------
    logic                     r_p1_valid, r_p1_vneg;
    logic signed [X_W+31:0]   r_p1_dprod;
    logic [X_W+31:0]          r_p1_uprod;
    logic signed [63:0]       r_p1_f;
    logic [X_W-1:0]           n_cmag;
    logic signed [31:0]       w_amp;

    assign w_amp  = $signed(r_amplitude);
    assign n_cmag = r_rt_c[X_W-1] ? X_W'(-r_rt_c) : X_W'(r_rt_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p1_valid <= 1'b0;
        else          r_p1_valid <= r_rt_valid;
        r_p1_dprod <= w_amp * r_rt_s;
        r_p1_uprod <= n_cmag * TWO_PI_Q29;
        r_p1_vneg  <= w_amp[31] ^ r_rt_f[63] ^ r_rt_c[X_W-1];
        r_p1_f     <= r_rt_f;
    end

    // ------------------------------------------------------------------
    // P2: rounded, saturated displacement; w = u*|A|; |f|.
    // ------------------------------------------------------------------
    logic                   r_p2_valid, r_p2_vneg;
    logic signed [31:0]     r_p2_disp;
    logic [63:0]            r_p2_w, r_p2_fmag;
    logic signed [X_W+31:0] n_drnd, n_dsh;
    logic signed [31:0]     n_disp;
    logic [31:0]            n_amag;
    logic [X_W+2:0]         n_u;

    always_comb begin
        n_drnd = r_p1_dprod + (X_W+32)'(64'sd536870912);
        n_dsh  = n_drnd >>> 30;
        if (n_dsh > (X_W+32)'(64'sd2147483647))
            n_disp = 32'sh7FFF_FFFF;
        else if (n_dsh < -(X_W+32)'(64'sd2147483648))
            n_disp = 32'sh8000_0000;
        else
            n_disp = n_dsh[31:0];
        n_amag = w_amp[31] ? 32'(-w_amp) : r_amplitude;
        n_u    = r_p1_uprod[X_W+31:29];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p2_valid <= 1'b0;
        else          r_p2_valid <= r_p1_valid;
        r_p2_disp <= n_disp;
        r_p2_w    <= 64'(n_u * n_amag);
        r_p2_fmag <= r_p1_f[63] ? 64'(-r_p1_f) : 64'(r_p1_f);
        r_p2_vneg <= r_p1_vneg;
    end

    // ------------------------------------------------------------------
    // P3: four partial products of w*|f|.
    // ------------------------------------------------------------------
    logic               r_p3_valid, r_p3_vneg;
    logic signed [31:0] r_p3_disp;
    logic [63:0]        r_p3_pp00, r_p3_pp01, r_p3_pp10, r_p3_pp11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p3_valid <= 1'b0;
        else          r_p3_valid <= r_p2_valid;
        r_p3_disp <= r_p2_disp;
        r_p3_vneg <= r_p2_vneg;
        r_p3_pp00 <= r_p2_w[31:0]  * r_p2_fmag[31:0];
        r_p3_pp01 <= r_p2_w[31:0]  * r_p2_fmag[63:32];
        r_p3_pp10 <= r_p2_w[63:32] * r_p2_fmag[31:0];
        r_p3_pp11 <= r_p2_w[63:32] * r_p2_fmag[63:32];
    end

    // ------------------------------------------------------------------
    // P4: full 128-bit velocity magnitude product.
    // ------------------------------------------------------------------
    logic               r_p4_valid, r_p4_vneg;
    logic signed [31:0] r_p4_disp;
    logic [127:0]       r_p4_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p4_valid <= 1'b0;
        else          r_p4_valid <= r_p3_valid;
        r_p4_disp <= r_p3_disp;
        r_p4_vneg <= r_p3_vneg;
        r_p4_prod <= 128'(r_p3_pp00) + (128'(r_p3_pp01) << 32)
                   + (128'(r_p3_pp10) << 32) + (128'(r_p3_pp11) << 64);
    end

    // ------------------------------------------------------------------
    // Output register: scale, saturate and sign the velocity.
    // ------------------------------------------------------------------
    logic               r_out_valid;
    logic signed [31:0] r_out_disp;
    logic signed [47:0] r_out_vel;
    logic               n_ovf;
    logic [47:0]        n_vmag;
    logic signed [47:0] n_vel;

    always_comb begin
        n_ovf  = |r_p4_prod[127:VSH+47];
        n_vmag = {1'b0, r_p4_prod[VSH+46:VSH]};
        if (n_ovf)
            n_vel = r_p4_vneg ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        else
            n_vel = r_p4_vneg ? $signed(-n_vmag) : $signed(n_vmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else          r_out_valid <= r_p4_valid;
        r_out_disp <= r_p4_disp;
        r_out_vel  <= n_vel;
    end

    assign o_valid        = r_out_valid;
    assign o_displacement = r_out_disp;
    assign o_velocity     = r_out_vel;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // An accepted time value enters the first stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_s1_valid)
        else $error("accepted item did not enter stage 1");

    // The divider count steps down by one each running cycle.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DIV_RUN && r_div_cnt != '0 && !r_div_req)
        |=> r_div_cnt == $past(r_div_cnt) - 1'b1)
        else $error("divider count skipped");

    // busy drops only when the divider has finished and no request waits.
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (r_state == DIV_IDLE && !r_div_req))
        else $error("busy dropped during rate update");

    // A register write always raises busy in the next cycle.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("register write did not start a rate update");

endmodule
